@@ rtl/byte_ring_fifo_with_lock_slot_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the byte ring FIFO core
// Concurrent checks on the core ports; empty bodies in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_WITH_LOCK_SLOT_CORE_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_LOCK_SLOT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BRFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brfl assertion failed");
`define BRFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brfl assertion failed");
`else
`define BRFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BRFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/brfl_pkg.sv @@
// ----------------------------------------------------------------------------
// brfl_pkg
// Shared types, codes and helper functions of the byte ring FIFO core.
// ----------------------------------------------------------------------------
package brfl_pkg;

    localparam int unsigned BSW = 9;  // buffer size / free count width
    localparam int unsigned DW  = 8;  // byte width

    typedef enum logic [2:0] {
        MODE_READ   = 3'd0,
        MODE_WRITE  = 3'd1,
        MODE_CLAIM  = 3'd2,
        MODE_LOCK   = 3'd3,
        MODE_UNLOCK = 3'd4,
        MODE_FILL   = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_mode           mode;
        logic [DW-1:0]   data_in;
        logic [DW-1:0]   slot_in;
    } t_request;

    typedef struct packed {
        logic            ok;
        logic [DW-1:0]   read_data;
        logic [DW-1:0]   claimed_slot;
        logic [BSW-1:0]  free_count;
    } t_result;

    // size in use: zero acts as one, above the storage depth acts as the depth
    function automatic logic [BSW-1:0] f_eff_size(logic [BSW-1:0] bs, int unsigned depth);
        logic [BSW-1:0] r;
        if (bs == '0) begin
            r = BSW'(1);
        end else if (32'(bs) > depth) begin
            r = BSW'(depth);
        end else begin
            r = bs;
        end
        return r;
    endfunction

    function automatic logic [BSW-1:0] f_advance(logic [BSW-1:0] idx, logic [BSW-1:0] size);
        logic [BSW:0] s;
        s = {1'b0, idx} + (BSW+1)'(1);
        if (s >= {1'b0, size}) begin
            return '0;
        end
        return s[BSW-1:0];
    endfunction

endpackage

@@ rtl/brfl_mem.sv @@
// ----------------------------------------------------------------------------
// brfl_mem
// Byte storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brfl_mem import brfl_pkg::*; #(
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

@@ rtl/brfl_ctrl.sv @@
// ----------------------------------------------------------------------------
// brfl_ctrl
// Sequencer, ring pointers, free count and lock slot; drives the storage
// ports and runs the clearing pass after reset.
// ----------------------------------------------------------------------------
module brfl_ctrl import brfl_pkg::*; #(
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    input  logic [BSW-1:0] i_cfg_size,
    input  logic           i_req_valid,
    input  t_request       i_req,
    output logic           o_req_ready,
    output logic           o_res_valid,
    output t_result        o_res,
    input  logic           i_res_ready,
    output logic           o_mem_we,
    output logic [AW-1:0]  o_mem_waddr,
    output logic [DW-1:0]  o_mem_wdata,
    output logic           o_mem_re,
    output logic [AW-1:0]  o_mem_raddr,
    input  logic [DW-1:0]  i_mem_rdata
);

    localparam logic [BSW-1:0] RST_SIZE = f_eff_size(BSW'(256), DEPTH);

    t_state         r_state, n_state;
    logic [AW-1:0]  r_clr_addr;
    t_request       r_req;
    logic [BSW-1:0] r_size;
    logic [BSW-1:0] r_head, n_head;
    logic [BSW-1:0] r_tail, n_tail;
    logic [BSW-1:0] r_free, n_free;
    logic           r_lock_act, n_lock_act;
    logic [DW-1:0]  r_lock_slot, n_lock_slot;
    logic           r_ok, n_ok;
    logic           r_rd_ok, n_rd_ok;
    logic [DW-1:0]  r_claim, n_claim;
    logic           head_locked, tail_locked;
    logic           x_we;
    logic [AW-1:0]  x_waddr;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_req_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_ready) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = x_waddr;
        o_mem_wdata = r_req.data_in;
        case (r_state)
            ST_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr_addr;
                o_mem_wdata = '0;
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
            end
            ST_EXEC: begin
                o_mem_we = x_we;
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    assign head_locked = r_lock_act && ({1'b0, r_lock_slot} == r_head);
    assign tail_locked = r_lock_act && ({1'b0, r_lock_slot} == r_tail);

    // operation datapath, active in ST_EXEC
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_free      = r_free;
        n_lock_act  = r_lock_act;
        n_lock_slot = r_lock_slot;
        n_ok        = 1'b0;
        n_rd_ok     = 1'b0;
        n_claim     = '0;
        x_we        = 1'b0;
        x_waddr     = AW'(r_head);
        o_mem_re    = 1'b0;
        o_mem_raddr = AW'(r_tail);
        if (r_state == ST_EXEC) begin
            case (r_req.mode)
                MODE_READ: begin
                    if ((r_free < r_size) && !tail_locked) begin
                        o_mem_re = 1'b1;
                        n_rd_ok  = 1'b1;
                        n_ok     = 1'b1;
                        n_tail   = f_advance(r_tail, r_size);
                        n_free   = r_free + BSW'(1);
                    end
                end
                MODE_WRITE, MODE_CLAIM: begin
                    if ((r_free != '0) && !head_locked) begin
                        x_we   = (r_req.mode == MODE_WRITE);
                        n_ok   = 1'b1;
                        n_head = f_advance(r_head, r_size);
                        n_free = r_free - BSW'(1);
                        if (r_req.mode == MODE_CLAIM) n_claim = r_head[DW-1:0];
                    end
                end
                MODE_LOCK: begin
                    n_lock_act  = 1'b1;
                    n_lock_slot = r_req.slot_in;
                    n_ok        = 1'b1;
                end
                MODE_UNLOCK: begin
                    n_lock_act  = 1'b0;
                    n_lock_slot = '0;
                    n_ok        = 1'b1;
                end
                MODE_FILL: begin
                    x_waddr = AW'(r_req.slot_in);
                    if ({1'b0, r_req.slot_in} < r_size) begin
                        x_we = 1'b1;
                        n_ok = 1'b1;
                    end
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_size      <= RST_SIZE;
            r_head      <= '0;
            r_tail      <= '0;
            r_free      <= RST_SIZE;
            r_lock_act  <= 1'b0;
            r_lock_slot <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
            if (i_cfg_valid) begin
                r_size      <= f_eff_size(i_cfg_size, DEPTH);
                r_free      <= f_eff_size(i_cfg_size, DEPTH);
                r_head      <= '0;
                r_tail      <= '0;
                r_lock_act  <= 1'b0;
                r_lock_slot <= '0;
            end else begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_free      <= n_free;
                r_lock_act  <= n_lock_act;
                r_lock_slot <= n_lock_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) r_req <= i_req;
        if (r_state == ST_EXEC) begin
            r_ok    <= n_ok;
            r_rd_ok <= n_rd_ok;
            r_claim <= n_claim;
        end
    end

    assign o_res.ok           = r_ok;
    assign o_res.read_data    = r_rd_ok ? i_mem_rdata : '0;
    assign o_res.claimed_slot = r_claim;
    assign o_res.free_count   = r_free;

endmodule

@@ rtl/brfl_out.sv @@
// ----------------------------------------------------------------------------
// brfl_out
// Output register for result transactions.
// ----------------------------------------------------------------------------
module brfl_out import brfl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_ready
);

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_res <= i_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ rtl/byte_ring_fifo_with_lock_slot_core.sv @@
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_lock_slot_core
// Circular byte FIFO with a programmable used length and one lockable slot.
// ----------------------------------------------------------------------------
// After reset the core zeroes its storage, one entry per cycle, over all DEPTH
// entries; it takes no transaction until that pass ends, while size writes on
// the config channel are taken at any time. Each request transaction then
// runs in order: the request is registered, the storage is accessed and the
// pointers update, and the registered read data passes into the output
// register once that register is free. The next request is taken once that
// result has moved to the output register, even while it waits for i_ready.
// A size write restarts the pointers and the lock but keeps the stored bytes.
`include "byte_ring_fifo_with_lock_slot_core_defines.svh"

module byte_ring_fifo_with_lock_slot_core import brfl_pkg::*; #(
    parameter int unsigned DEPTH = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [BSW-1:0] i_cfg_buffer_size,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [2:0]     i_mode,
    input  logic [DW-1:0]  i_data_in,
    input  logic [DW-1:0]  i_slot_in,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_ok,
    output logic [DW-1:0]  o_read_data,
    output logic [DW-1:0]  o_claimed_slot,
    output logic [BSW-1:0] o_free_count
);

    localparam int unsigned AW = $clog2(DEPTH);

    t_request      req;
    t_result       res, out_res;
    logic          res_valid, res_ready;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [DW-1:0] mem_wdata, mem_rdata;

    assign o_cfg_ready  = 1'b1;
    assign req.mode     = t_mode'(i_mode);
    assign req.data_in  = i_data_in;
    assign req.slot_in  = i_slot_in;

    brfl_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_size  (i_cfg_buffer_size),
        .i_req_valid (i_valid),
        .i_req       (req),
        .o_req_ready (o_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    brfl_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    brfl_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_ready (res_ready),
        .o_valid (o_valid),
        .o_res   (out_res),
        .i_ready (i_ready)
    );

    assign o_ok           = out_res.ok;
    assign o_read_data    = out_res.read_data;
    assign o_claimed_slot = out_res.claimed_slot;
    assign o_free_count   = out_res.free_count;

    `BRFL_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `BRFL_ASSERT_IMP(a_free_in_range, i_clk, i_rst_n, o_valid, 32'(o_free_count) <= DEPTH)
    `BRFL_ASSERT_IMP(a_refused_zero, i_clk, i_rst_n, o_valid && !o_ok, (o_read_data == '0) && (o_claimed_slot == '0))

endmodule
